// ===== hw/rtl/chte_pkg.sv =====
// Shared constants, types and helpers for the chained hash table engine.
package chte_pkg;

    localparam int BUCKETS     = 16;
    localparam int CHAIN_DEPTH = 8;
    localparam int SLOTS       = BUCKETS * CHAIN_DEPTH;

    localparam int ACTION_W     = 2;
    localparam int KEY_W        = 31;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int BUCKET_OUT_W = 4;
    localparam int POS_OUT_W    = 3;

    localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IDX_W    = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int LEN_W    = $clog2(CHAIN_DEPTH + 1);
    localparam int ADDR_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_DELETE = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_slot             wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // BUCKETS is a power of two, so this reduces to the low key bits.
    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
        return BUCKET_W'(key % BUCKETS);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [BUCKET_W-1:0] bucket,
                                                    input logic [IDX_W-1:0]    idx);
        return ADDR_W'(bucket) * ADDR_W'(CHAIN_DEPTH) + ADDR_W'(idx);
    endfunction

endpackage

// ===== hw/rtl/chte_in_if.sv =====
// Request channel: action, key and value with a valid/ready handshake.
interface chte_in_if import chte_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [KEY_W-1:0]           key;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, action, key, value, input ready);
    modport sink   (input valid, action, key, value, output ready);
endinterface

// ===== hw/rtl/chte_out_if.sv =====
// Response channel: status, bucket, chain position and value with valid/ready.
interface chte_out_if import chte_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [BUCKET_OUT_W-1:0]    bucket_number;
    logic [POS_OUT_W-1:0]       chain_position;
    logic signed [VALUE_W-1:0]  found_value;

    modport source (output valid, status, bucket_number, chain_position, found_value,
                    input ready);
    modport sink   (input valid, status, bucket_number, chain_position, found_value,
                    output ready);
endinterface

// ===== hw/rtl/chained_hash_table_engine.sv =====
// Top level of the chained hash table engine: slot memory and sequencer.
// Flow: IDLE accepts an item, SCAN walks a non-empty chain, ACT applies the update, SHIFT
// compacts after a delete (only the slots after its hit), and DONE loads the result register.
// Throughput: one item at a time; the chain walk reads one slot per cycle from the single
// read port of the slot memory.
// Reset (synchronous, active low) empties every chain and drops any pending result.
module chained_hash_table_engine import chte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chte_in_if.sink     i_in,
    chte_out_if.source  o_out
);
    t_ram_req ram_req;
    t_slot    ram_rdata;

    chte_slot_ram #(
        .WORDS (SLOTS),
        .WIDTH ($bits(t_slot))
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    chte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );
endmodule

// ===== hw/rtl/chte_slot_ram.sv =====
// Simple dual-port slot memory with registered read.
module chte_slot_ram #(
    parameter int WORDS = 128,
    parameter int WIDTH = 63
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/chte_ctrl.sv =====
// Sequencer: chain walk, update, delete compaction, chain lengths and result register.
module chte_ctrl import chte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chte_in_if.sink     i_in,
    chte_out_if.source  o_out,
    output t_ram_req    o_ram_req,
    input  t_slot       i_ram_rdata
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_ACT   = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [LEN_W-1:0]       r_len_tab [BUCKETS];
    logic                   len_we;
    logic [LEN_W-1:0]       len_wdata;

    logic [ACTION_W-1:0]    r_action, n_action;
    logic [KEY_W-1:0]       r_key, n_key;
    logic [VALUE_W-1:0]     r_value, n_value;
    logic [BUCKET_W-1:0]    r_bucket, n_bucket;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_hit, n_hit;
    logic [VALUE_W-1:0]     r_found, n_found;
    t_status                r_status, n_status;
    logic [IDX_W-1:0]       r_pos, n_pos;

    logic                   r_out_valid, n_out_valid;
    logic                   out_load;
    logic [BUCKET_W-1:0]    in_bucket;

    assign in_bucket = bucket_of(i_in.key);
    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_key       = r_key;
        n_value     = r_value;
        n_bucket    = r_bucket;
        n_len       = r_len;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_found     = r_found;
        n_status    = r_status;
        n_pos       = r_pos;
        len_we      = 1'b0;
        len_wdata   = r_len;
        out_load    = 1'b0;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = slot_addr(r_bucket, r_idx);
        o_ram_req.wdata = i_ram_rdata;
        o_ram_req.raddr = slot_addr(in_bucket, '0);

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_action = i_in.action;
                    n_key    = i_in.key;
                    n_value  = i_in.value;
                    n_bucket = in_bucket;
                    n_len    = r_len_tab[in_bucket];
                    n_idx    = '0;
                    n_hit    = 1'b0;
                    n_state  = (r_len_tab[in_bucket] != '0) ? S_SCAN : S_ACT;
                end
            end
            S_SCAN: begin
                // Read data belongs to slot r_idx; the next slot is fetched in parallel.
                if (i_ram_rdata.key == r_key) begin
                    n_hit   = 1'b1;
                    n_found = i_ram_rdata.value;
                    n_state = S_ACT;
                end else if ((LEN_W'(r_idx) + 1'b1) == r_len) begin
                    n_state = S_ACT;
                end else begin
                    n_idx           = r_idx + 1'b1;
                    o_ram_req.raddr = slot_addr(r_bucket, r_idx + 1'b1);
                end
            end
            S_ACT: begin
                n_status = ST_MISS;
                n_pos    = '0;
                n_found  = '0;
                n_state  = S_DONE;
                unique case (r_action)
                    ACT_INSERT: begin
                        o_ram_req.wdata = '{key: r_key, value: r_value};
                        if (r_hit) begin
                            o_ram_req.we = 1'b1;
                            n_status     = ST_OK;
                            n_pos        = r_idx;
                        end else if (r_len < LEN_W'(CHAIN_DEPTH)) begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = slot_addr(r_bucket, IDX_W'(r_len));
                            len_we          = 1'b1;
                            len_wdata       = r_len + 1'b1;
                            n_status        = ST_OK;
                            n_pos           = IDX_W'(r_len);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                    ACT_SEARCH: begin
                        if (r_hit) begin
                            n_status = ST_OK;
                            n_pos    = r_idx;
                            n_found  = r_found;
                        end
                    end
                    ACT_DELETE: begin
                        if (r_hit) begin
                            n_status  = ST_OK;
                            n_pos     = r_idx;
                            len_we    = 1'b1;
                            len_wdata = r_len - 1'b1;
                            // Later entries move down one slot to keep chain order.
                            if ((LEN_W'(r_idx) + 1'b1) < r_len) begin
                                o_ram_req.raddr = slot_addr(r_bucket, r_idx + 1'b1);
                                n_state         = S_SHIFT;
                            end
                        end
                    end
                    default: begin
                        n_status = ST_MISS;
                    end
                endcase
            end
            S_SHIFT: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.wdata = i_ram_rdata;
                if (((LEN_W + 1)'(r_idx) + 2'd2) < (LEN_W + 1)'(r_len)) begin
                    n_idx           = r_idx + 1'b1;
                    o_ram_req.raddr = slot_addr(r_bucket, r_idx + 1'b1 + 1'b1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int b = 0; b < BUCKETS; b++) begin
                r_len_tab[b] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (len_we) begin
                r_len_tab[r_bucket] <= len_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_key    <= n_key;
        r_value  <= n_value;
        r_bucket <= n_bucket;
        r_len    <= n_len;
        r_idx    <= n_idx;
        r_hit    <= n_hit;
        r_found  <= n_found;
        r_status <= n_status;
        r_pos    <= n_pos;
        if (out_load) begin
            o_out.status         <= r_status;
            o_out.bucket_number  <= BUCKET_OUT_W'(r_bucket);
            o_out.chain_position <= POS_OUT_W'(r_pos);
            o_out.found_value    <= r_found;
        end
    end

    assign o_out.valid = r_out_valid;
endmodule

// ===== test/chained_hash_table_engine_tb.sv =====
// Testbench for the chained hash table engine: directed and random requests checked by a table model.
module chained_hash_table_engine_tb;
    import chte_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int POOL_KEYS     = 12;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 420;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [BUCKET_OUT_W-1:0] bucket_number;
        logic [POS_OUT_W-1:0]    chain_position;
        logic [VALUE_W-1:0]      found_value;
    } t_lookup_rsp;

    logic i_clk;
    logic i_rst_n;

    chte_in_if  req_if();
    chte_out_if rsp_if();

    chained_hash_table_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    // Shadow copy of the slot memory; valid slots of a bucket always form a prefix.
    logic               slot_used [SLOTS];
    logic [KEY_W-1:0]   slot_key  [SLOTS];
    logic [VALUE_W-1:0] slot_data [SLOTS];

    logic [KEY_W-1:0] key_pool [BUCKETS][POOL_KEYS];
    t_lookup_rsp      pending_results [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_lookup_rsp apply_table_op(input logic [ACTION_W-1:0] act,
                                                   input logic [KEY_W-1:0]    key,
                                                   input logic [VALUE_W-1:0]  val);
        t_lookup_rsp rsp;
        int bucket;
        int base;
        int hit;
        int used;
        int i;
        bucket = int'(key % BUCKETS);
        base   = bucket * CHAIN_DEPTH;
        hit    = CHAIN_DEPTH;
        used   = 0;
        for (i = 0; i < CHAIN_DEPTH; i++) begin
            if (slot_used[base + i]) begin
                used++;
                if (hit == CHAIN_DEPTH && slot_key[base + i] == key) hit = i;
            end
        end
        rsp.status         = ST_MISS;
        rsp.bucket_number  = BUCKET_OUT_W'(bucket);
        rsp.chain_position = '0;
        rsp.found_value    = '0;
        case (act)
            ACT_INSERT: begin
                if (hit < CHAIN_DEPTH) begin
                    slot_data[base + hit] = val;
                    rsp.status            = ST_OK;
                    rsp.chain_position    = POS_OUT_W'(hit);
                end else if (used < CHAIN_DEPTH) begin
                    slot_used[base + used] = 1'b1;
                    slot_key[base + used]  = key;
                    slot_data[base + used] = val;
                    rsp.status             = ST_OK;
                    rsp.chain_position     = POS_OUT_W'(used);
                end else begin
                    rsp.status = ST_FULL;
                end
            end
            ACT_SEARCH: begin
                if (hit < CHAIN_DEPTH) begin
                    rsp.status         = ST_OK;
                    rsp.chain_position = POS_OUT_W'(hit);
                    rsp.found_value    = slot_data[base + hit];
                end
            end
            ACT_DELETE: begin
                if (hit < CHAIN_DEPTH) begin
                    // Later entries move down one slot so the chain keeps its order.
                    for (i = hit; i + 1 < used; i++) begin
                        slot_key[base + i]  = slot_key[base + i + 1];
                        slot_data[base + i] = slot_data[base + i + 1];
                    end
                    slot_used[base + used - 1] = 1'b0;
                    rsp.status                 = ST_OK;
                    rsp.chain_position         = POS_OUT_W'(hit);
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [KEY_W-1:0]    key,
                                input logic [VALUE_W-1:0]  val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= act;
        req_if.key    <= key;
        req_if.value  <= val;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.insert(pending_results.size(), apply_table_op(act, key, val));
    endtask

    task automatic send_random_request();
        logic [ACTION_W-1:0] act;
        logic [KEY_W-1:0]    key;
        int                  pick;
        pick = $urandom_range(99);
        if (pick < 40)      act = ACT_INSERT;
        else if (pick < 70) act = ACT_SEARCH;
        else if (pick < 95) act = ACT_DELETE;
        else                act = ACT_UNUSED;
        // Mostly a small set of keys per bucket, so chains fill, hit and compact.
        if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(BUCKETS - 1)][$urandom_range(POOL_KEYS - 1)];
        else
            key = KEY_W'($urandom());
        send_request(act, key, $urandom());
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_request(ACT_SEARCH, 31'd5, 32'h1234_5678);
        send_request(ACT_DELETE, 31'd5, 32'h0);
        send_request(ACT_UNUSED, 31'd5, 32'hFFFF_FFFF);
        wait_for_results();
    endtask

    task automatic test_extreme_fields();
        send_request(ACT_INSERT, 31'd0, 32'h8000_0000);
        send_request(ACT_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(ACT_SEARCH, 31'd0, 32'h0);
        send_request(ACT_SEARCH, 31'h7FFF_FFFF, 32'h0);
        send_request(ACT_INSERT, 31'd0, 32'hFFFF_FFFF);
        send_request(ACT_SEARCH, 31'd0, 32'h0);
        wait_for_results();
    endtask

    task automatic test_full_chain();
        for (int k = 0; k < CHAIN_DEPTH; k++)
            send_request(ACT_INSERT, KEY_W'(3 + BUCKETS * k), $urandom());
        send_request(ACT_INSERT, KEY_W'(3 + BUCKETS * CHAIN_DEPTH), $urandom());
        send_request(ACT_INSERT, KEY_W'(3 + BUCKETS * 2), $urandom());
        send_request(ACT_SEARCH, KEY_W'(3 + BUCKETS * 7), 32'h0);
        send_request(ACT_DELETE, KEY_W'(3 + BUCKETS * 2), 32'h0);
        send_request(ACT_SEARCH, KEY_W'(3 + BUCKETS * 7), 32'h0);
        send_request(ACT_DELETE, KEY_W'(3), 32'h0);
        send_request(ACT_DELETE, KEY_W'(3 + BUCKETS * 7), 32'h0);
        send_request(ACT_SEARCH, KEY_W'(3 + BUCKETS * 2), 32'h0);
        send_request(ACT_INSERT, KEY_W'(3 + BUCKETS * CHAIN_DEPTH), $urandom());
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_request();
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left     <= HOLD_CYCLES;
        repeat (40) send_random_request();
        wait_for_results();
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_lookup_rsp got;
        t_lookup_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.status, rsp_if.bucket_number, rsp_if.chain_position,
                    rsp_if.found_value};
            if (pending_results.size() == 0) begin
                report_error($sformatf("unexpected beat: status %0d bucket %0d pos %0d value %0d",
                                       got.status, got.bucket_number, got.chain_position,
                                       $signed(got.found_value)));
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_error($sformatf({"expected status %0d bucket %0d pos %0d value %0d, ",
                                            "got status %0d bucket %0d pos %0d value %0d"},
                                           want.status, want.bucket_number, want.chain_position,
                                           $signed(want.found_value), got.status,
                                           got.bucket_number, got.chain_position,
                                           $signed(got.found_value)));
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.action <= ACT_INSERT;
        req_if.key    <= '0;
        req_if.value  <= '0;
        for (int s = 0; s < SLOTS; s++) slot_used[s] = 1'b0;
        // Each bucket gets six small keys, five with random upper bits and one near the top of the key range.
        for (int b = 0; b < BUCKETS; b++) begin
            for (int k = 0; k < POOL_KEYS; k++) begin
                if (k < POOL_KEYS / 2)
                    key_pool[b][k] = KEY_W'(b + BUCKETS * k);
                else if (k == POOL_KEYS - 1)
                    key_pool[b][k] = KEY_W'(31'h7FFF_FFFF - (BUCKETS - 1 - b));
                else
                    key_pool[b][k] = KEY_W'(($urandom() / BUCKETS) * BUCKETS + b);
            end
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_extreme_fields();
        test_full_chain();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 63, 0);
        test_output_backpressure();
        test_random_traffic(PHASE_ITEMS, 0, 63);
        test_random_traffic(PHASE_ITEMS, 23, 23);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
